// ===== design/fbc_pkg.sv =====
// Shared types and constants for the frustum box cull core.
package fbc_pkg;

    // Matrix and box geometry
    localparam int MAT_ELEMS = 16;
    localparam int MAT_DIM   = 4;
    localparam int PLANES    = 6;
    localparam int AXES      = 3;

    // Field widths
    localparam int ELEM_W  = 24;             // Q8.16 matrix element
    localparam int COEF_W  = ELEM_W + 1;     // sum or difference of two elements
    localparam int COORD_W = 16;             // Q12.4 box coordinate
    localparam int IDX_W   = 4;
    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int SUM_W   = PROD_W + 2;     // three products plus the scaled offset
    localparam int OFS_SH  = 4;              // lines the Q.16 offset up with Q.20 products

    // Stream packing
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 8;

    typedef logic signed [ELEM_W-1:0]  elem_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [IDX_W-1:0]          idx_t;

    // Plane components 0..2 are the normal, 3 the offset
    typedef coef_t [MAT_DIM-1:0] plane_t;
    typedef plane_t [PLANES-1:0] plane_set_t;
    typedef coord_t [AXES-1:0]   vec3_t;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } cmd_t;

    // Stage load strobes handed to the plane evaluators
    typedef struct packed
    {
        logic load_a;    // capture plane and positive vertex
        logic load_b;    // capture the three products
    } stage_en_t;

endpackage

// ===== design/fbc_matrix.sv =====
// View-projection matrix storage and clip plane derivation.
module fbc_matrix
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_en,
    input  fbc_pkg::idx_t        load_index,
    input  fbc_pkg::elem_t       load_value,
    output fbc_pkg::plane_set_t  planes
);

    fbc_pkg::elem_t mat_reg [fbc_pkg::MAT_ELEMS];

    // Element write, one per load transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbc_pkg::MAT_ELEMS; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (load_en)
        begin
            mat_reg[load_index] <= load_value;
        end
    end

    // Plane p: row p/2, even p adds, odd p subtracts; component k from column k
    for (genvar p = 0; p < fbc_pkg::PLANES; p++)
    begin : g_plane
        for (genvar k = 0; k < fbc_pkg::MAT_DIM; k++)
        begin : g_comp
            localparam int ROW   = p / 2;
            localparam int W_IDX = k * fbc_pkg::MAT_DIM + fbc_pkg::MAT_DIM - 1;
            localparam int E_IDX = k * fbc_pkg::MAT_DIM + ROW;

            fbc_pkg::coef_t w_ext;
            fbc_pkg::coef_t e_ext;

            assign w_ext = fbc_pkg::coef_t'(mat_reg[W_IDX]);
            assign e_ext = fbc_pkg::coef_t'(mat_reg[E_IDX]);

            if (p % 2 == 0)
            begin : g_add
                assign planes[p][k] = w_ext + e_ext;
            end
            else
            begin : g_sub
                assign planes[p][k] = w_ext - e_ext;
            end
        end
    end

endmodule

// ===== design/fbc_plane_eval.sv =====
// One clip plane: positive vertex pick, products, and the strictly-negative test.
module fbc_plane_eval
(
    input  logic                clk,
    input  fbc_pkg::stage_en_t  en,
    input  fbc_pkg::plane_t     plane,
    input  fbc_pkg::vec3_t      box_lo,
    input  fbc_pkg::vec3_t      box_hi,
    output logic                cull
);

    fbc_pkg::coef_t  a_coef_reg [fbc_pkg::MAT_DIM];
    fbc_pkg::coord_t a_vert_reg [fbc_pkg::AXES];
    logic            a_zero_reg;

    fbc_pkg::prod_t  b_prod_reg [fbc_pkg::AXES];
    fbc_pkg::coef_t  b_ofs_reg;
    logic            b_zero_reg;

    fbc_pkg::coord_t vert_next [fbc_pkg::AXES];
    fbc_pkg::sum_t   plane_val;

    // Vertex that maximizes the plane value, per axis
    always_comb
    begin
        for (int k = 0; k < fbc_pkg::AXES; k++)
        begin
            if ($signed(plane[k]) < 0)
            begin
                vert_next[k] = ($signed(box_lo[k]) < $signed(box_hi[k])) ? box_lo[k] : box_hi[k];
            end
            else
            begin
                vert_next[k] = ($signed(box_lo[k]) < $signed(box_hi[k])) ? box_hi[k] : box_lo[k];
            end
        end
    end

    // Stage A: plane snapshot and chosen vertex
    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            for (int k = 0; k < fbc_pkg::MAT_DIM; k++)
            begin
                a_coef_reg[k] <= plane[k];
            end
            for (int k = 0; k < fbc_pkg::AXES; k++)
            begin
                a_vert_reg[k] <= vert_next[k];
            end
            a_zero_reg <= (plane[0] == '0) && (plane[1] == '0) && (plane[2] == '0);
        end
    end

    // Stage B: one multiplier per axis, operands sign-extended to the product width
    always_ff @(posedge clk)
    begin
        if (en.load_b)
        begin
            for (int k = 0; k < fbc_pkg::AXES; k++)
            begin
                b_prod_reg[k] <= fbc_pkg::prod_t'(a_coef_reg[k])
                               * fbc_pkg::prod_t'(a_vert_reg[k]);
            end
            b_ofs_reg  <= a_coef_reg[fbc_pkg::MAT_DIM-1];
            b_zero_reg <= a_zero_reg;
        end
    end

    // Plane value at the positive vertex; a zero normal never culls
    always_comb
    begin
        plane_val = fbc_pkg::sum_t'(b_prod_reg[0])
                  + fbc_pkg::sum_t'(b_prod_reg[1])
                  + fbc_pkg::sum_t'(b_prod_reg[2])
                  + (fbc_pkg::sum_t'(b_ofs_reg) <<< fbc_pkg::OFS_SH);
        cull = !b_zero_reg && plane_val[fbc_pkg::SUM_W-1];
    end

endmodule

// ===== design/frustum_box_cull_core.sv =====
// Frustum box cull core: matrix load, plane evaluation pipeline and result stage.
//
// Usage:
//   Slave stream (s_axis_*) carries both kinds of transaction, told apart by
//   s_axis_tuser. A load transaction writes one Q8.16 element of the 4x4
//   view-projection matrix (index = column*4 + row) and produces no result.
//   A test transaction carries a Q12.4 box and produces one result on the
//   master stream (m_axis_*): bit 0 is 1 when the box is visible, 0 when it
//   lies fully outside one of the six clip planes.
//   A test passes through three register stages: plane/vertex pick, the
//   25x16 multipliers, and the sum with its sign test.
//   Throughput: one transaction per cycle while s_axis_tready is high, loads
//   and tests mixed freely; a load takes effect for every test accepted after it.
//   Each stage holds its item until the next stage is free, so while the
//   receiver stalls the three stages fill: up to three tests are held
//   before s_axis_tready drops; loads are taken whenever s_axis_tready is high.
//   Reset clears the matrix to zeros (every box then reads visible) and
//   empties the pipeline.
module frustum_box_cull_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // elem_index, elem_value, min_x, min_y, min_z, max_x, max_y, max_z, zero pad
    input  logic [fbc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // command
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // visible, zero pad
    output logic [fbc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    logic                 a_valid_reg;
    logic                 a_valid_next;
    logic                 b_valid_reg;
    logic                 b_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 visible_reg;
    logic                 visible_next;

    logic                 accept;
    logic                 test_acc;
    logic                 load_acc;
    logic                 a_go;
    logic                 b_go;

    fbc_pkg::stage_en_t   stage_en;
    fbc_pkg::plane_set_t  planes;
    fbc_pkg::vec3_t       box_lo;
    fbc_pkg::vec3_t       box_hi;
    logic [fbc_pkg::PLANES-1:0] culls;

    // Input field unpacking
    assign box_lo[0] = s_axis_tdata[43:28];
    assign box_lo[1] = s_axis_tdata[59:44];
    assign box_lo[2] = s_axis_tdata[75:60];
    assign box_hi[0] = s_axis_tdata[91:76];
    assign box_hi[1] = s_axis_tdata[107:92];
    assign box_hi[2] = s_axis_tdata[123:108];

    // Stage advance: each stage moves when the next one is empty or moving
    assign b_go          = b_valid_reg && (!out_valid_reg || m_axis_tready);
    assign a_go          = a_valid_reg && (!b_valid_reg || b_go);
    assign s_axis_tready = !a_valid_reg || a_go;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign test_acc      = accept && (s_axis_tuser == fbc_pkg::CMD_TEST);
    assign load_acc      = accept && (s_axis_tuser == fbc_pkg::CMD_LOAD);

    assign stage_en.load_a = test_acc;
    assign stage_en.load_b = a_go;

    fbc_matrix u_matrix
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_acc),
        .load_index (s_axis_tdata[3:0]),
        .load_value (s_axis_tdata[27:4]),
        .planes     (planes)
    );

    for (genvar p = 0; p < fbc_pkg::PLANES; p++)
    begin : g_eval
        fbc_plane_eval u_eval
        (
            .clk    (clk),
            .en     (stage_en),
            .plane  (planes[p]),
            .box_lo (box_lo),
            .box_hi (box_hi),
            .cull   (culls[p])
        );
    end

    // Valid flags and result
    always_comb
    begin
        a_valid_next   = a_valid_reg;
        b_valid_next   = b_valid_reg;
        out_valid_next = out_valid_reg;
        visible_next   = ~|culls;
        if (test_acc)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_go)
        begin
            a_valid_next = 1'b0;
        end
        if (a_go)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_go)
        begin
            b_valid_next = 1'b0;
        end
        if (b_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            visible_reg <= visible_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(fbc_pkg::OUT_DATA_W-1){1'b0}}, visible_reg};

    // Checks on the stage control
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (a_valid_reg && b_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while the pipeline has room");

    a_test_enters: assert property (@(posedge clk) disable iff (!rst_n)
        test_acc |=> a_valid_reg)
        else $error("accepted test not held in stage A");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        a_go |=> b_valid_reg)
        else $error("stage A item lost on its way to stage B");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        b_go |=> (m_axis_tvalid && $past(m_axis_tready || !out_valid_reg)))
        else $error("result overwritten before it was taken");

endmodule

// ===== sim/frustum_box_cull_core_test.sv =====
// Self-checking stream testbench for the frustum box cull core: matrix loads, box tests, stalls.
module frustum_box_cull_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 1000;   // cycles with no transaction on either side
    localparam int ITEM_TARGET  = 1000;
    localparam int MAX_IDLE     = 14;
    localparam int DRAIN_CYCLES = 8;

    // Matrix and box flavors for the random scenes
    typedef enum int
    {
        MAT_FULL,      // any 24-bit value
        MAT_UNIT,      // within +/-2.0, like a real view-projection
        MAT_SPARSE     // half zeros, so zero normals show up
    } mat_style_t;

    typedef enum int
    {
        BOX_FULL,      // corners anywhere, min above max half the time
        BOX_TIGHT      // small box around a random center
    } box_style_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [fbc_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           s_axis_tuser  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [fbc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Predictor state: copy of the matrix as seen by the next accepted test
    fbc_pkg::elem_t view_elems [fbc_pkg::MAT_ELEMS];
    logic  visible_q [$];

    bit    no_idle;
    int    rx_stall_left;
    int    rx_wait;
    int    quiet_cycles;
    int    failures;
    int    loads_sent;
    int    tests_sent;
    int    culled_sent;
    int    results_seen;
    logic  want_visible;

    frustum_box_cull_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Visibility of a box against the six planes of the current matrix
    function automatic logic box_visible(input fbc_pkg::vec3_t lo, input fbc_pkg::vec3_t hi);
        longint pl [4];
        longint best;
        longint v_lo;
        longint v_hi;
        int     row;
        logic   visible;
        visible = 1'b1;
        for (int p = 0; p < fbc_pkg::PLANES; p++)
        begin
            row = p >> 1;
            for (int k = 0; k < fbc_pkg::MAT_DIM; k++)
            begin
                if (p % 2 == 0)
                    pl[k] = longint'(view_elems[k*4+3]) + longint'(view_elems[k*4+row]);
                else
                    pl[k] = longint'(view_elems[k*4+3]) - longint'(view_elems[k*4+row]);
            end
            // zero normal never culls
            if (pl[0] != 0 || pl[1] != 0 || pl[2] != 0)
            begin
                best = pl[3] * 16;
                for (int k = 0; k < fbc_pkg::AXES; k++)
                begin
                    v_lo = pl[k] * longint'($signed(lo[k]));
                    v_hi = pl[k] * longint'($signed(hi[k]));
                    best += (v_lo > v_hi) ? v_lo : v_hi;
                end
                if (best < 0)
                    visible = 1'b0;
            end
        end
        return visible;
    endfunction

    function automatic fbc_pkg::elem_t rand_elem(input mat_style_t style);
        fbc_pkg::elem_t val;
        case (style)
            MAT_UNIT:   val = fbc_pkg::elem_t'(int'($urandom_range(0, 262143)) - 131072);
            MAT_SPARSE: val = ($urandom_range(0, 1) == 0) ? fbc_pkg::elem_t'(0)
                                                          : fbc_pkg::elem_t'($urandom());
            default:    val = fbc_pkg::elem_t'($urandom());
        endcase
        return val;
    endfunction

    function automatic void rand_box(input box_style_t style, output fbc_pkg::vec3_t lo,
                                     output fbc_pkg::vec3_t hi);
        int center;
        int half;
        for (int a = 0; a < fbc_pkg::AXES; a++)
        begin
            if (style == BOX_TIGHT)
            begin
                center = int'($signed(fbc_pkg::coord_t'($urandom())));
                half   = $urandom_range(0, 255);
                lo[a]  = fbc_pkg::coord_t'(center - half);
                hi[a]  = fbc_pkg::coord_t'(center + half);
            end
            else
            begin
                lo[a] = fbc_pkg::coord_t'($urandom());
                hi[a] = fbc_pkg::coord_t'($urandom());
            end
        end
    endfunction

    // One transaction on the slave stream; the model is updated on acceptance
    task automatic send_item(input fbc_pkg::cmd_t cmd, input fbc_pkg::idx_t idx,
                             input fbc_pkg::elem_t val,
                             input fbc_pkg::vec3_t lo, input fbc_pkg::vec3_t hi);
        int   gap;
        logic vis;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, hi, lo, val, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cmd == fbc_pkg::CMD_LOAD)
        begin
            view_elems[idx] = val;
            loads_sent++;
        end
        else
        begin
            vis = box_visible(lo, hi);
            visible_q.push_back(vis);
            tests_sent++;
            if (!vis)
                culled_sent++;
        end
    endtask

    // Load with junk in the box fields
    task automatic load_elem(input fbc_pkg::idx_t idx, input fbc_pkg::elem_t val);
        fbc_pkg::vec3_t lo;
        fbc_pkg::vec3_t hi;
        rand_box(BOX_FULL, lo, hi);
        send_item(fbc_pkg::CMD_LOAD, idx, val, lo, hi);
    endtask

    // Test with junk in the element fields
    task automatic test_box(input fbc_pkg::vec3_t lo, input fbc_pkg::vec3_t hi);
        send_item(fbc_pkg::CMD_TEST, fbc_pkg::idx_t'($urandom()),
                  fbc_pkg::elem_t'($urandom()), lo, hi);
    endtask

    task automatic load_matrix(input mat_style_t style);
        for (int i = 0; i < fbc_pkg::MAT_ELEMS; i++)
            load_elem(fbc_pkg::idx_t'(i), rand_elem(style));
    endtask

    // Hold off the sender until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (visible_q.size() != 0)
            @(posedge clk);
    endtask

    // Matrix cleared by reset: every box visible
    task automatic check_reset_matrix();
        test_box({3{fbc_pkg::coord_t'(-32768)}}, {3{fbc_pkg::coord_t'(32767)}});
        test_box({3{fbc_pkg::coord_t'(32767)}}, {3{fbc_pkg::coord_t'(-32768)}});
        test_box({3{fbc_pkg::coord_t'(0)}}, {3{fbc_pkg::coord_t'(0)}});
    endtask

    // Only offsets nonzero: all normals zero, nothing culled
    task automatic check_zero_normal();
        load_elem(fbc_pkg::idx_t'(15), fbc_pkg::elem_t'(-8388608));
        load_elem(fbc_pkg::idx_t'(12), fbc_pkg::elem_t'(8388607));
        test_box({3{fbc_pkg::coord_t'(0)}}, {3{fbc_pkg::coord_t'(0)}});
        test_box({3{fbc_pkg::coord_t'(-32768)}}, {3{fbc_pkg::coord_t'(-32768)}});
    endtask

    // One x-facing plane set: sign boundary, extremes, min above max
    task automatic check_single_plane();
        load_elem(fbc_pkg::idx_t'(12), fbc_pkg::elem_t'(0));
        load_elem(fbc_pkg::idx_t'(3), fbc_pkg::elem_t'(16));
        load_elem(fbc_pkg::idx_t'(15), fbc_pkg::elem_t'(-1));
        // plane value exactly zero is not outside
        test_box({3{fbc_pkg::coord_t'(1)}}, {3{fbc_pkg::coord_t'(1)}});
        test_box({3{fbc_pkg::coord_t'(0)}}, {3{fbc_pkg::coord_t'(0)}});
        load_elem(fbc_pkg::idx_t'(3), fbc_pkg::elem_t'(8388607));
        load_elem(fbc_pkg::idx_t'(15), fbc_pkg::elem_t'(-8388608));
        test_box({3{fbc_pkg::coord_t'(-32768)}}, {3{fbc_pkg::coord_t'(-32768)}});
        test_box({3{fbc_pkg::coord_t'(-32768)}}, {3{fbc_pkg::coord_t'(32767)}});
        test_box({3{fbc_pkg::coord_t'(32767)}}, {3{fbc_pkg::coord_t'(-32768)}});
        test_box({3{fbc_pkg::coord_t'(10)}}, {3{fbc_pkg::coord_t'(-32768)}});
        load_elem(fbc_pkg::idx_t'(0), fbc_pkg::elem_t'(-8388608));
        test_box({3{fbc_pkg::coord_t'(-32768)}}, {3{fbc_pkg::coord_t'(-32768)}});
    endtask

    // Back-to-back tests with no idling on either side, then a full drain
    task automatic check_back_pressure();
        fbc_pkg::vec3_t lo;
        fbc_pkg::vec3_t hi;
        no_idle = 1'b1;
        load_matrix(MAT_UNIT);
        repeat (40)
        begin
            rand_box(BOX_TIGHT, lo, hi);
            test_box(lo, hi);
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    // Scenes: a matrix (full or patched) followed by a run of boxes
    task automatic check_random_scenes();
        fbc_pkg::vec3_t lo;
        fbc_pkg::vec3_t hi;
        mat_style_t     mstyle;
        box_style_t     bstyle;
        while (loads_sent + tests_sent < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            mstyle  = mat_style_t'($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    load_elem(fbc_pkg::idx_t'($urandom()), rand_elem(mstyle));
            end
            else
                load_matrix(mstyle);
            repeat ($urandom_range(4, 24))
            begin
                bstyle = ($urandom_range(0, 9) < 6) ? BOX_TIGHT : BOX_FULL;
                rand_box(bstyle, lo, hi);
                test_box(lo, hi);
            end
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random stall after each result, or none during bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= 0;
        end
        else if (rx_stall_left != 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            if (rx_stall_left == 1)
                m_axis_tready <= 1'b1;
        end
        else if (!m_axis_tready)
            m_axis_tready <= 1'b1;
        else if (m_axis_tvalid)
        begin
            rx_wait = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (rx_wait != 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall_left <= rx_wait;
            end
        end
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (visible_q.size() == 0)
            begin
                $error("visible: no result expected, actual %0d", m_axis_tdata[0]);
                failures++;
            end
            else
            begin
                want_visible = visible_q.pop_front();
                if (m_axis_tdata[0] !== want_visible)
                begin
                    $error("visible: expected %0d, actual %0d", want_visible, m_axis_tdata[0]);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < fbc_pkg::MAT_ELEMS; i++)
            view_elems[i] = '0;
        no_idle = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        check_reset_matrix();
        check_zero_normal();
        check_single_plane();
        check_back_pressure();
        check_random_scenes();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d element loads and %0d box tests (%0d predicted culled), %0d results",
                 loads_sent, tests_sent, culled_sent, results_seen);
        $display("Covered reset matrix, zero normals, sign boundary, swapped corners, stalls");
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
